>>> rtl/core/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared codes, field widths and types of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Field widths at the block ports
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int IDX_FIELD_W = 10;
  localparam int VER_FIELD_W = 16;
  localparam int LIMIT_W     = 11;

  // Default storage parameters
  localparam int DEF_INDEX_BITS   = 10;
  localparam int DEF_VERSION_BITS = 16;

  // Slot limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } gha_state_e;

  // Memory port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

>>> rtl/core/gha_slot_mem.sv
// ----------------------------------------------------------------------------
// gha_slot_mem
// Per-slot RAM holding the alive bit and the version, one read and one write
// port, registered read data.
// ----------------------------------------------------------------------------
module gha_slot_mem #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 17
) (
  input  logic              clk_i,
  input  gha_pkg::mem_ctl_t ctl_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o
);
  import gha_pkg::*;

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/gha_free_stack.sv
// ----------------------------------------------------------------------------
// gha_free_stack
// LIFO storage of freed slots, each entry the slot index and its version at
// the time it was freed. The stack pointer lives with the sequencer.
// ----------------------------------------------------------------------------
module gha_free_stack #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 26
) (
  input  logic              clk_i,
  input  gha_pkg::mem_ctl_t ctl_i,
  input  logic [ADDR_W-1:0] pop_addr_i,
  input  logic [ADDR_W-1:0] push_addr_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic [DATA_W-1:0] top_data_o
);
  import gha_pkg::*;

  logic [DATA_W-1:0] stack_mem [2**ADDR_W];
  logic [DATA_W-1:0] top_q;

  // Push
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      stack_mem[push_addr_i] <= push_data_i;
    end
  end

  // Registered read of the top entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      top_q <= stack_mem[pop_addr_i];
    end
  end

  assign top_data_o = top_q;

endmodule

>>> rtl/core/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator: slot/version handle allocator
// The input beat starts the slot and stack RAM reads and is captured; the update
//   and the result register follow in the exec state once the output is free.
// No new beat is taken until the write-back of the current item; the RAM read
//   comes before the write-back, and a held result stalls the update.
// Reset clears counters and control only; the fresh mark bounds valid slots.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
  parameter int INDEX_BITS   = gha_pkg::DEF_INDEX_BITS,
  parameter int VERSION_BITS = gha_pkg::DEF_VERSION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [gha_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gha_pkg::OP_W-1:0]        operation_i,
  input  logic [gha_pkg::IDX_FIELD_W-1:0] handle_index_i,
  input  logic [gha_pkg::VER_FIELD_W-1:0] handle_version_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gha_pkg::STATUS_W-1:0]    status_o,
  output logic [gha_pkg::IDX_FIELD_W-1:0] new_index_o,
  output logic [gha_pkg::VER_FIELD_W-1:0] new_version_o,
  output logic [gha_pkg::IDX_FIELD_W-1:0] live_count_o
);
  import gha_pkg::*;

  localparam int CntW      = INDEX_BITS + 1;
  localparam int SlotW     = VERSION_BITS + 1;
  localparam int StackW    = INDEX_BITS + VERSION_BITS;
  localparam int CmpW      = (CntW > LIMIT_W) ? CntW : LIMIT_W;
  localparam int SlotCount = 2 ** INDEX_BITS;

  // Control and state registers
  gha_state_e             state_q, state_d;
  logic [LIMIT_W-1:0]     slot_limit_q;
  logic [CntW-1:0]        freed_depth_q, freed_depth_d;
  logic [CntW-1:0]        fresh_mark_q, fresh_mark_d;
  logic [INDEX_BITS-1:0]  alive_total_q, alive_total_d;

  // Captured item
  logic [OP_W-1:0]        op_q;
  logic [INDEX_BITS-1:0]  idx_q;
  logic [VER_FIELD_W-1:0] ver_q;

  // Output register
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [IDX_FIELD_W-1:0] new_index_q, new_index_d;
  logic [VER_FIELD_W-1:0] new_version_q, new_version_d;
  logic [IDX_FIELD_W-1:0] live_count_q, live_count_d;

  // Handshake and sequencing
  logic                   in_accept;
  logic                   advance;
  logic [INDEX_BITS-1:0]  in_idx;
  logic [CntW-1:0]        depth_dec;

  // Memory ports
  mem_ctl_t               slot_ctl, stack_ctl;
  logic [INDEX_BITS-1:0]  slot_wr_addr;
  logic [SlotW-1:0]       slot_wr_data, slot_rd_data;
  logic [StackW-1:0]      stack_wr_data, stack_rd_data;
  logic                   slot_we, stack_we;

  // Decoded read data
  logic                   rd_alive;
  logic [VERSION_BITS-1:0] rd_version;
  logic [INDEX_BITS-1:0]  top_idx;
  logic [VERSION_BITS-1:0] top_version;

  // Update datapath
  logic                   handle_ok;
  logic                   fresh_ok;
  logic [CmpW-1:0]        limit_ext, fresh_ext;
  logic [INDEX_BITS-1:0]  made_idx;
  logic [VERSION_BITS-1:0] made_ver;

  assign in_idx    = INDEX_BITS'(handle_index_i);
  assign in_accept = in_valid_i && !in_stall_o;
  assign depth_dec = freed_depth_q - CntW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (advance) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    advance    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_EXEC: begin
        advance = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Slot and stack RAMs
  assign slot_ctl.rd_en  = in_accept;
  assign slot_ctl.wr_en  = slot_we && advance;
  assign stack_ctl.rd_en = in_accept;
  assign stack_ctl.wr_en = stack_we && advance;

  gha_slot_mem #(
    .ADDR_W (INDEX_BITS),
    .DATA_W (SlotW)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .ctl_i     (slot_ctl),
    .rd_addr_i (in_idx),
    .wr_addr_i (slot_wr_addr),
    .wr_data_i (slot_wr_data),
    .rd_data_o (slot_rd_data)
  );

  gha_free_stack #(
    .ADDR_W (INDEX_BITS),
    .DATA_W (StackW)
  ) u_free_stack (
    .clk_i       (clk_i),
    .ctl_i       (stack_ctl),
    .pop_addr_i  (depth_dec[INDEX_BITS-1:0]),
    .push_addr_i (freed_depth_q[INDEX_BITS-1:0]),
    .push_data_i (stack_wr_data),
    .top_data_o  (stack_rd_data)
  );

  assign rd_alive    = slot_rd_data[VERSION_BITS];
  assign rd_version  = slot_rd_data[VERSION_BITS-1:0];
  assign top_idx     = stack_rd_data[StackW-1:VERSION_BITS];
  assign top_version = stack_rd_data[VERSION_BITS-1:0];

  // Handle check: slots at or past the fresh mark were never written
  assign handle_ok = (idx_q != '0) && (CntW'(idx_q) < fresh_mark_q) && rd_alive &&
                     (VER_FIELD_W'(rd_version) == ver_q);

  // Fresh slot available below the effective limit
  assign limit_ext = CmpW'(slot_limit_q);
  assign fresh_ext = CmpW'(fresh_mark_q);
  assign fresh_ok  = (fresh_ext < limit_ext) && (fresh_ext < CmpW'(SlotCount));

  // Update and result
  always_comb begin
    freed_depth_d = freed_depth_q;
    fresh_mark_d  = fresh_mark_q;
    alive_total_d = alive_total_q;
    slot_we       = 1'b0;
    stack_we      = 1'b0;
    slot_wr_addr  = idx_q;
    slot_wr_data  = {1'b0, rd_version};
    stack_wr_data = {idx_q, rd_version};
    made_idx      = '0;
    made_ver      = '0;
    status_d      = ST_DEAD;
    case (op_q)
      OP_CREATE: begin
        if (freed_depth_q != '0) begin
          // reuse the last freed slot with its version bumped
          made_idx      = top_idx;
          made_ver      = top_version + VERSION_BITS'(1);
          freed_depth_d = depth_dec;
          slot_we       = 1'b1;
        end else if (fresh_ok) begin
          made_idx     = fresh_mark_q[INDEX_BITS-1:0];
          made_ver     = '0;
          fresh_mark_d = fresh_mark_q + CntW'(1);
          slot_we      = 1'b1;
        end
        if (slot_we) begin
          slot_wr_addr  = made_idx;
          slot_wr_data  = {1'b1, made_ver};
          alive_total_d = alive_total_q + INDEX_BITS'(1);
          status_d      = ST_OK;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_DESTROY: begin
        if (handle_ok) begin
          slot_we       = 1'b1;
          stack_we      = 1'b1;
          freed_depth_d = freed_depth_q + CntW'(1);
          if (alive_total_q != '0) begin
            alive_total_d = alive_total_q - INDEX_BITS'(1);
          end
          status_d = ST_OK;
        end
      end
      OP_QUERY: begin
        status_d = handle_ok ? ST_OK : ST_DEAD;
      end
      default: begin
        status_d = ST_DEAD;
      end
    endcase
    new_index_d   = IDX_FIELD_W'(made_idx);
    new_version_d = VER_FIELD_W'(made_ver);
    live_count_d  = IDX_FIELD_W'(alive_total_d);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slot_limit_q  <= LIMIT_RESET;
      freed_depth_q <= '0;
      fresh_mark_q  <= CntW'(1);
      alive_total_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        slot_limit_q <= cfg_wdata_i;
      end
      if (advance) begin
        freed_depth_q <= freed_depth_d;
        fresh_mark_q  <= fresh_mark_d;
        alive_total_q <= alive_total_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= operation_i;
      idx_q <= in_idx;
      ver_q <= handle_version_i;
    end
    if (advance) begin
      status_q      <= status_d;
      new_index_q   <= new_index_d;
      new_version_q <= new_version_d;
      live_count_q  <= live_count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign new_index_o   = new_index_q;
  assign new_version_o = new_version_q;
  assign live_count_o  = live_count_q;

`ifndef SYNTH
  // every handed-out slot is either live or waiting on the freed stack
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW'(alive_total_q) + freed_depth_q) == (fresh_mark_q - CntW'(1)))
    else $error("live count plus freed depth does not match handed-out slots");

  // the fresh mark never passes the slot count
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(fresh_mark_q) <= CmpW'(SlotCount))
    else $error("fresh mark beyond slot count");

  // an accepted beat blocks the next one while the sequencer is in the exec state
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (in_stall_o && state_q == S_EXEC))
    else $error("second beat accepted during update");
`endif

endmodule

>>> tb/tb_generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator
// Self-checking bench for the slot/version handle allocator. A directed table
// walks reset behavior, invalid handles, stale versions, slot reuse and the
// full condition under several slot limits. Random traffic follows and mixes
// creates with destroys and queries of recently issued handles. Every accepted
// result beat is compared against an in-bench allocator model or a pinned result.
// ----------------------------------------------------------------------------
module tb_generational_handle_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  localparam int SLOT_CNT       = 1 << DEF_INDEX_BITS;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // opcode the block defines no action for
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [IDX_FIELD_W-1:0] idx;
    logic [VER_FIELD_W-1:0] ver;
    logic [IDX_FIELD_W-1:0] live;
  } alloc_result_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] idx;
    logic [VER_FIELD_W-1:0] ver;
  } handle_t;

  typedef struct packed {
    bit            pinned;
    alloc_result_t res;
  } typed_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_LIMIT
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [OP_W-1:0]        op;
    logic [IDX_FIELD_W-1:0] idx;
    logic [VER_FIELD_W-1:0] ver;
    bit                     pinned;
    alloc_result_t          res;
    logic [LIMIT_W-1:0]     limit;
  } dir_row_t;

  // DUT signals
  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [LIMIT_W-1:0]     cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [OP_W-1:0]        operation_i;
  logic [IDX_FIELD_W-1:0] handle_index_i;
  logic [VER_FIELD_W-1:0] handle_version_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [STATUS_W-1:0]    status_o;
  logic [IDX_FIELD_W-1:0] new_index_o;
  logic [VER_FIELD_W-1:0] new_version_o;
  logic [IDX_FIELD_W-1:0] live_count_o;

  // allocator model state
  bit [VER_FIELD_W-1:0] slot_ver    [SLOT_CNT];
  bit                   slot_live   [SLOT_CNT];
  bit [IDX_FIELD_W-1:0] freed_slots [SLOT_CNT];
  int unsigned          freed_depth = 0;
  int unsigned          fresh_mark  = 1;
  int unsigned          live_total  = 0;
  logic [LIMIT_W-1:0]   limit_q     = LIMIT_RESET;

  // bench bookkeeping
  alloc_result_t outcome_q [$];
  typed_t        typed_q   [$];
  handle_t       issued_q  [$];
  dir_row_t      dir_rows  [$];
  int            fail_cnt    = 0;
  int            beat_cnt    = 0;
  int            result_cnt  = 0;
  int            reuse_cnt   = 0;
  int            full_cnt    = 0;
  int            limit_cnt   = 0;
  int            peak_live   = 0;
  int            quiet_cycles = 0;
  int            tx_idle_pct = 10;
  int            rx_idle_pct = 10;
  bit            hold_req    = 1'b0;

  // monitor scratch
  alloc_result_t pred_res;
  alloc_result_t want_res;
  typed_t        typed_ent;
  handle_t       new_handle;
  bit            moved;

  generational_handle_allocator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .handle_index_i   (handle_index_i),
    .handle_version_i (handle_version_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .new_index_o      (new_index_o),
    .new_version_o    (new_version_o),
    .live_count_o     (live_count_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one line per mismatch, counted
  task automatic note_fail(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // live test: slot in use, alive and version matching
  function automatic bit handle_alive(input logic [IDX_FIELD_W-1:0] idx,
                                      input logic [VER_FIELD_W-1:0] ver);
    if (idx == '0 || 32'(idx) >= fresh_mark) return 1'b0;
    return slot_live[idx] && (slot_ver[idx] == ver);
  endfunction

  // model of one operation; updates the model state
  function automatic alloc_result_t alloc_outcome(input logic [OP_W-1:0]        op,
                                                  input logic [IDX_FIELD_W-1:0] idx,
                                                  input logic [VER_FIELD_W-1:0] ver);
    alloc_result_t          r;
    logic [IDX_FIELD_W-1:0] slot;
    int unsigned            cap;
    bit                     got;
    r        = '0;
    r.status = ST_DEAD;
    got      = 1'b0;
    slot     = '0;
    case (op)
      OP_CREATE: begin
        cap = (32'(limit_q) > SLOT_CNT) ? SLOT_CNT : 32'(limit_q);
        if (freed_depth > 0) begin
          freed_depth--;
          slot = freed_slots[freed_depth[IDX_FIELD_W-1:0]];
          slot_ver[slot] = slot_ver[slot] + 1'b1;
          got = 1'b1;
          reuse_cnt++;
        end else if (fresh_mark < cap) begin
          slot = fresh_mark[IDX_FIELD_W-1:0];
          fresh_mark++;
          slot_ver[slot] = '0;
          got = 1'b1;
        end
        if (got) begin
          slot_live[slot] = 1'b1;
          live_total++;
          r.status = ST_OK;
          r.idx    = slot;
          r.ver    = slot_ver[slot];
        end else begin
          r.status = ST_FULL;
          full_cnt++;
        end
      end
      OP_DESTROY: begin
        if (handle_alive(idx, ver)) begin
          slot_live[idx] = 1'b0;
          if (live_total > 0) live_total--;
          if (freed_depth < SLOT_CNT) begin
            freed_slots[freed_depth[IDX_FIELD_W-1:0]] = idx;
            freed_depth++;
          end
          r.status = ST_OK;
        end
      end
      OP_QUERY: begin
        if (handle_alive(idx, ver)) r.status = ST_OK;
      end
      default: ;
    endcase
    r.live = live_total[IDX_FIELD_W-1:0];
    return r;
  endfunction

  // sampling at the rising edge: predict input beats, check result beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        moved    = 1'b1;
        beat_cnt++;
        pred_res = alloc_outcome(operation_i, handle_index_i, handle_version_i);
        if (operation_i == OP_CREATE && pred_res.status == ST_OK) begin
          new_handle.idx = pred_res.idx;
          new_handle.ver = pred_res.ver;
          issued_q.insert(issued_q.size(), new_handle);
          if (issued_q.size() > 256) void'(issued_q.pop_front());
        end
        if (int'(pred_res.live) > peak_live) peak_live = int'(pred_res.live);
        typed_ent = typed_q.pop_front();
        outcome_q.insert(outcome_q.size(), typed_ent.pinned ? typed_ent.res : pred_res);
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        result_cnt++;
        if (outcome_q.size() == 0) begin
          note_fail("result beat with no outcome pending");
        end else begin
          want_res = outcome_q.pop_front();
          if (status_o !== want_res.status)
            note_fail($sformatf("status got %0d want %0d", status_o, want_res.status));
          if (new_index_o !== want_res.idx)
            note_fail($sformatf("new_index got %0d want %0d", new_index_o, want_res.idx));
          if (new_version_o !== want_res.ver)
            note_fail($sformatf("new_version got %0d want %0d",
                                new_version_o, want_res.ver));
          if (live_count_o !== want_res.live)
            note_fail($sformatf("live_count got %0d want %0d",
                                live_count_o, want_res.live));
        end
      end
      // watchdog on stalled traffic
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stall, or a long hold when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= (rx_idle_pct > 0) && ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // offer one beat at a falling edge and hold it until taken
  task automatic send_item(input logic [OP_W-1:0]        op,
                           input logic [IDX_FIELD_W-1:0] idx,
                           input logic [VER_FIELD_W-1:0] ver,
                           input bit                     pinned,
                           input alloc_result_t          res);
    typed_t ent;
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    ent.pinned = pinned;
    ent.res    = res;
    typed_q.insert(typed_q.size(), ent);
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    handle_index_i   <= idx;
    handle_version_i <= ver;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write the slot limit once all results are in
  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_q  = value;
    limit_cnt++;
  endtask

  // random beat: mostly handles issued recently, some noise
  task automatic send_random(input int create_pct);
    logic [OP_W-1:0]        op;
    logic [IDX_FIELD_W-1:0] idx;
    logic [VER_FIELD_W-1:0] ver;
    handle_t                h;
    int                     pick;
    int                     span;
    if ($urandom_range(0, 99) < create_pct) begin
      op = OP_CREATE;
    end else begin
      pick = $urandom_range(0, 19);
      op   = (pick < 11) ? OP_DESTROY : (pick < 19) ? OP_QUERY : OP_UNUSED;
    end
    pick = $urandom_range(0, 9);
    if (issued_q.size() == 0 || pick == 0) begin
      idx = IDX_FIELD_W'($urandom_range(0, SLOT_CNT - 1));
      ver = VER_FIELD_W'($urandom_range(0, 65535));
    end else begin
      span = (issued_q.size() < 32) ? issued_q.size() : 32;
      h    = issued_q[issued_q.size() - 1 - $urandom_range(0, span - 1)];
      idx  = h.idx;
      ver  = h.ver;
      if (pick == 1) ver = VER_FIELD_W'($urandom_range(0, 65535));
      else if (pick == 2) ver = h.ver + 1'b1;
    end
    send_item(op, idx, ver, 1'b0, '0);
  endtask

  task automatic run_random(input int n, input int create_pct);
    repeat (n) send_random(create_pct);
  endtask

  // directed table builders
  task automatic add_beat(input logic [OP_W-1:0] op, input logic [IDX_FIELD_W-1:0] idx,
                          input logic [VER_FIELD_W-1:0] ver);
    dir_row_t row;
    row = '{kind: ROW_BEAT, op: op, idx: idx, ver: ver,
            pinned: 1'b0, res: '0, limit: '0};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_pinned(input logic [OP_W-1:0] op, input logic [IDX_FIELD_W-1:0] idx,
                            input logic [VER_FIELD_W-1:0] ver,
                            input logic [STATUS_W-1:0] st,
                            input logic [IDX_FIELD_W-1:0] ni,
                            input logic [VER_FIELD_W-1:0] nv,
                            input logic [IDX_FIELD_W-1:0] lc);
    dir_row_t row;
    row = '{kind: ROW_BEAT, op: op, idx: idx, ver: ver, pinned: 1'b1,
            res: '{status: st, idx: ni, ver: nv, live: lc}, limit: '0};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_limit(input logic [LIMIT_W-1:0] value);
    dir_row_t row;
    row = '{kind: ROW_LIMIT, op: OP_QUERY, idx: '0, ver: '0,
            pinned: 1'b0, res: '0, limit: value};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // main sequence
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = LIMIT_RESET;
    in_valid_i       = 1'b0;
    operation_i      = OP_QUERY;
    handle_index_i   = '0;
    handle_version_i = '0;

    // invalid handles straight after reset
    add_pinned(OP_QUERY,   10'd0,    16'd0,      ST_DEAD, '0, '0, 10'd0);
    add_pinned(OP_DESTROY, 10'd0,    16'd0,      ST_DEAD, '0, '0, 10'd0);
    add_pinned(OP_QUERY,   10'd1023, 16'hFFFF,   ST_DEAD, '0, '0, 10'd0);
    // fresh slots start at one with version zero
    add_pinned(OP_CREATE,  10'd1023, 16'hFFFF,   ST_OK, 10'd1, 16'd0, 10'd1);
    add_pinned(OP_CREATE,  10'd0,    16'd0,      ST_OK, 10'd2, 16'd0, 10'd2);
    add_pinned(OP_QUERY,   10'd1,    16'd0,      ST_OK,   '0, '0, 10'd2);
    add_pinned(OP_QUERY,   10'd1,    16'hFFFF,   ST_DEAD, '0, '0, 10'd2);
    // slot at the fresh mark
    add_pinned(OP_QUERY,   10'd3,    16'd0,      ST_DEAD, '0, '0, 10'd2);
    // stale version, then a real destroy and a second one
    add_pinned(OP_DESTROY, 10'd1,    16'd1,      ST_DEAD, '0, '0, 10'd2);
    add_pinned(OP_DESTROY, 10'd1,    16'd0,      ST_OK,   '0, '0, 10'd1);
    add_pinned(OP_DESTROY, 10'd1,    16'd0,      ST_DEAD, '0, '0, 10'd1);
    add_pinned(OP_QUERY,   10'd1,    16'd0,      ST_DEAD, '0, '0, 10'd1);
    // reuse from the freed stack bumps the version
    add_pinned(OP_CREATE,  10'd0,    16'd0,      ST_OK, 10'd1, 16'd1, 10'd2);
    add_beat  (OP_DESTROY, 10'd2,    16'd0);
    // unused opcode changes nothing
    add_pinned(OP_UNUSED,  10'd2,    16'd0,      ST_DEAD, '0, '0, 10'd1);
    add_pinned(OP_UNUSED,  10'd1023, 16'hFFFF,   ST_DEAD, '0, '0, 10'd1);
    add_beat  (OP_CREATE,  10'd0,    16'd0);
    add_beat  (OP_CREATE,  10'd0,    16'd0);
    // limit reached by the fresh mark; freed slots still reused
    add_limit (11'd4);
    add_pinned(OP_CREATE,  10'd0,    16'd0,      ST_FULL, '0, '0, 10'd3);
    add_beat  (OP_DESTROY, 10'd3,    16'd0);
    add_beat  (OP_CREATE,  10'd0,    16'd0);
    add_pinned(OP_CREATE,  10'd0,    16'd0,      ST_FULL, '0, '0, 10'd3);
    // zero limit, then a limit past the memory size
    add_limit (11'd0);
    add_pinned(OP_CREATE,  10'd0,    16'd0,      ST_FULL, '0, '0, 10'd3);
    add_limit (11'd2047);
    add_beat  (OP_CREATE,  10'd0,    16'd0);
    add_beat  (OP_QUERY,   10'd4,    16'd0);

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed walk
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LIMIT) set_limit(dir_rows[i].limit);
      else send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].ver,
                     dir_rows[i].pinned, dir_rows[i].res);
    end

    // small pool with plenty of reuse
    set_limit(11'd16);
    run_random(200, 45);
    // only freed slots can be handed out
    set_limit(11'd1);
    run_random(80, 40);
    set_limit(11'd0);
    run_random(60, 50);
    // long result hold while beats keep coming
    set_limit(LIMIT_RESET);
    hold_req = 1'b1;
    run_random(120, 50);
    // fill every slot with no idling on either side
    set_limit(11'd2047);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(1100, 97);
    // random limit, normal idling
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    set_limit(LIMIT_W'($urandom_range(1, SLOT_CNT)));
    run_random(120, 30);

    // drain
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("run covered %0d operation beats over %0d slot limit settings",
             beat_cnt, limit_cnt + 1);
    $display("%0d results checked: %0d slot reuses, %0d full creates, peak live %0d",
             result_cnt, reuse_cnt, full_cnt, peak_live);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
